[rtl/core/uvsph_pkg.sv]
`default_nettype none
package uvsph_pkg;

	localparam int unsigned CORDIC_STAGES_DEF = 16;
	localparam int unsigned ANGLE_BITS_DEF    = 18;

	// cordic datapath width: Q2.30 plus guard
	localparam int unsigned CW = 33;
	// divisor and remainder width (4 * 255 fits)
	localparam int unsigned DIV_DW = 10;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam int COORD_LIMIT = 65535;

	localparam logic [15:0] RADIUS_RST  = 16'd256;
	localparam logic [7:0]  STACKS_RST  = 8'd16;
	localparam logic [7:0]  SEGS_RST    = 8'd16;

	typedef enum logic [1:0] {
		REG_RADIUS  = 2'd0,
		REG_STACKS  = 2'd1,
		REG_SEGS    = 2'd2,
		REG_UNUSED  = 2'd3
	} reg_addr_t;

	typedef struct packed {
		logic        valid;
		logic        quad;
		logic        oor;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
	} side_t;

	function automatic logic signed [CW-1:0] atan_val(input int unsigned i);
		logic signed [CW-1:0] v;
		begin
			case (i)
				0:  v = 33'sd536870912;
				1:  v = 33'sd316933406;
				2:  v = 33'sd167458907;
				3:  v = 33'sd85004756;
				4:  v = 33'sd42667331;
				5:  v = 33'sd21354465;
				6:  v = 33'sd10679838;
				7:  v = 33'sd5340245;
				8:  v = 33'sd2670163;
				9:  v = 33'sd1335087;
				10: v = 33'sd667544;
				11: v = 33'sd333772;
				12: v = 33'sd166886;
				13: v = 33'sd83443;
				14: v = 33'sd41722;
				15: v = 33'sd20861;
				16: v = 33'sd10430;
				17: v = 33'sd5215;
				18: v = 33'sd2608;
				19: v = 33'sd1304;
				20: v = 33'sd652;
				21: v = 33'sd326;
				22: v = 33'sd163;
				23: v = 33'sd81;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	function automatic logic signed [16:0] sat17(input logic signed [69:0] v);
		logic signed [16:0] r;
		begin
			if (v > 70'sd65535)
				r = 17'sd65535;
			else if (v < -70'sd65535)
				r = -17'sd65535;
			else
				r = v[16:0];
			return r;
		end
	endfunction

endpackage
`default_nettype wire

[rtl/core/uvsph_div.sv]
`default_nettype none
module uvsph_div #(
	parameter int unsigned NW = 27,
	parameter int unsigned DW = 10
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quo
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [DW-1:0] den_s [NW];

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [DW-1:0] rp;
		logic [NW-1:0] np;
		logic [NW-1:0] qp;
		logic [DW-1:0] dp;
		logic [DW:0]   trial;
		logic          ge;

		if (g == 0) begin : g_first
			assign rp = '0;
			assign np = num;
			assign qp = '0;
			assign dp = den;
		end else begin : g_next
			assign rp = rem_s[g-1];
			assign np = num_s[g-1];
			assign qp = quo_s[g-1];
			assign dp = den_s[g-1];
		end

		// one restoring step: shift in the next dividend bit
		assign trial = {rp, np[NW-1-g]};
		assign ge    = trial >= {1'b0, dp};

		always_ff @(posedge clk) begin
			rem_s[g] <= ge ? DW'(trial - {1'b0, dp}) : trial[DW-1:0];
			quo_s[g] <= {qp[NW-2:0], ge};
			num_s[g] <= np;
			den_s[g] <= dp;
		end
	end

	assign quo = quo_s[NW-1];

endmodule
`default_nettype wire

[rtl/core/uvsph_cordic.sv]
`default_nettype none
module uvsph_cordic #(
	parameter int unsigned STAGES = 16,
	parameter int unsigned AB     = 18
) (
	input  wire logic                          clk,
	input  wire logic [AB-1:0]                 angle,
	output logic signed [uvsph_pkg::CW-1:0]    cos_v,
	output logic signed [uvsph_pkg::CW-1:0]    sin_v
);

	localparam int unsigned W = uvsph_pkg::CW;

	logic signed [W-1:0] x_s [STAGES];
	logic signed [W-1:0] y_s [STAGES];
	logic signed [W-1:0] z_s [STAGES];
	logic [1:0]          qd_s [STAGES];

	logic [29:0] resid;
	assign resid = {angle[AB-3:0], (32-AB)'(0)};

	for (genvar g = 0; g < STAGES; g++) begin : g_rot
		logic signed [W-1:0] xp, yp, zp;
		logic [1:0]          qp;
		logic signed [W-1:0] at;

		if (g == 0) begin : g_first
			assign xp = uvsph_pkg::CORDIC_GAIN;
			assign yp = '0;
			assign zp = W'(resid);
			assign qp = angle[AB-1:AB-2];
		end else begin : g_next
			assign xp = x_s[g-1];
			assign yp = y_s[g-1];
			assign zp = z_s[g-1];
			assign qp = qd_s[g-1];
		end

		assign at = uvsph_pkg::atan_val(g);

		always_ff @(posedge clk) begin
			if (!zp[W-1]) begin
				x_s[g] <= xp - (yp >>> g);
				y_s[g] <= yp + (xp >>> g);
				z_s[g] <= zp - at;
			end else begin
				x_s[g] <= xp + (yp >>> g);
				y_s[g] <= yp - (xp >>> g);
				z_s[g] <= zp + at;
			end
			qd_s[g] <= qp;
		end
	end

	// fold the quadrant back in
	always_ff @(posedge clk) begin
		case (qd_s[STAGES-1])
			2'd0: begin
				cos_v <= x_s[STAGES-1];
				sin_v <= y_s[STAGES-1];
			end
			2'd1: begin
				cos_v <= -y_s[STAGES-1];
				sin_v <= x_s[STAGES-1];
			end
			2'd2: begin
				cos_v <= -x_s[STAGES-1];
				sin_v <= -y_s[STAGES-1];
			end
			default: begin
				cos_v <= y_s[STAGES-1];
				sin_v <= -x_s[STAGES-1];
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/uv_sphere_vertex_generator_unit.sv]
`default_nettype none
// UV sphere vertex generator.
// Command channel: present stack_index and segment_index with start; a grid
// point is taken at every clock edge where start is high and busy is low.
// busy stays low, so one point can enter on every cycle.
// Result channel: done is high for one cycle with coord_x/y/z (signed Q8.8),
// quad_valid, the four quad corners and out_of_range. Results leave in
// order, one per point. The point passes ANGLE_BITS + 9 divider stages
// (one quotient bit a stage, the first loaded at the accepting edge),
// CORDIC_STAGES + 1 sine/cosine stages and four stages of scaling
// multipliers and output register.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Registers sit on the APB port: radius at 0x0, stack_count at 0x4,
// segment_count at 0x8. Write them only while no point is in flight.
// Reset clears the result strobe and the pipeline valid bits and loads
// radius 1.0, 16 stacks and 16 segments.
module uv_sphere_vertex_generator_unit #(
	parameter int unsigned CORDIC_STAGES = uvsph_pkg::CORDIC_STAGES_DEF,
	parameter int unsigned ANGLE_BITS    = uvsph_pkg::ANGLE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [7:0]         stack_index,
	input  wire logic [7:0]         segment_index,
	output logic                    done,
	output logic signed [16:0]      coord_x,
	output logic signed [16:0]      coord_y,
	output logic signed [16:0]      coord_z,
	output logic                    quad_valid,
	output logic [15:0]             corner_a,
	output logic [15:0]             corner_b,
	output logic [15:0]             corner_c,
	output logic [15:0]             corner_d,
	output logic                    out_of_range
);

	localparam int unsigned NW  = ANGLE_BITS + 9;
	localparam int unsigned DW  = uvsph_pkg::DIV_DW;
	localparam int unsigned W   = uvsph_pkg::CW;
	localparam int unsigned SBL = NW + CORDIC_STAGES + 4;

	// ---------------- configuration ----------------
	logic [15:0] radius_q;
	logic [7:0]  stacks_q;
	logic [7:0]  segs_q;
	uvsph_pkg::reg_addr_t addr;

	assign addr   = uvsph_pkg::reg_addr_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= uvsph_pkg::RADIUS_RST;
			stacks_q <= uvsph_pkg::STACKS_RST;
			segs_q   <= uvsph_pkg::SEGS_RST;
		end else if (psel && penable && pwrite) begin
			unique case (addr)
				uvsph_pkg::REG_RADIUS: radius_q <= pwdata[15:0];
				uvsph_pkg::REG_STACKS: stacks_q <= pwdata[7:0];
				uvsph_pkg::REG_SEGS:   segs_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (addr)
			uvsph_pkg::REG_RADIUS: prdata = {16'd0, radius_q};
			uvsph_pkg::REG_STACKS: prdata = {24'd0, stacks_q};
			uvsph_pkg::REG_SEGS:   prdata = {24'd0, segs_q};
			default:               prdata = '0;
		endcase
	end

	// ---------------- input stage ----------------
	logic        take;
	logic [7:0]  stacks, segs;
	logic [NW-1:0] phi_num, theta_num, quo_phi, quo_theta;
	logic [DW-1:0] phi_den, theta_den;
	logic [16:0] row_base;
	logic [15:0] ca;
	uvsph_pkg::side_t side_in;

	assign busy   = 1'b0;
	assign take   = start && !busy;
	// a zero count acts as one
	assign stacks = (stacks_q == 8'd0) ? 8'd1 : stacks_q;
	assign segs   = (segs_q == 8'd0) ? 8'd1 : segs_q;

	assign phi_num   = (NW'(stack_index) << (ANGLE_BITS + 1)) + NW'({stacks, 1'b0});
	assign phi_den   = DW'({stacks, 2'b00});
	assign theta_num = (NW'(segment_index) << (ANGLE_BITS + 1)) + NW'(segs);
	assign theta_den = DW'({segs, 1'b0});

	assign row_base = stack_index * ({1'b0, segs} + 9'd1);
	assign ca       = 16'(row_base + 17'(segment_index));

	always_comb begin
		side_in.valid = take;
		side_in.quad  = (stack_index < stacks) && (segment_index < segs);
		side_in.oor   = (stack_index > stacks) || (segment_index > segs);
		side_in.a     = '0;
		side_in.b     = '0;
		side_in.c     = '0;
		side_in.d     = '0;
		if (side_in.quad) begin
			side_in.a = ca;
			side_in.b = 16'(ca + 16'(segs) + 16'd1);
			side_in.c = 16'(ca + 16'd1);
			side_in.d = 16'(ca + 16'(segs) + 16'd2);
		end
	end

	uvsph_div #(.NW(NW), .DW(DW)) u_div_phi (
		.clk (clk),
		.num (phi_num),
		.den (phi_den),
		.quo (quo_phi)
	);

	uvsph_div #(.NW(NW), .DW(DW)) u_div_theta (
		.clk (clk),
		.num (theta_num),
		.den (theta_den),
		.quo (quo_theta)
	);

	logic signed [W-1:0] cp, sp, ct, st;

	uvsph_cordic #(.STAGES(CORDIC_STAGES), .AB(ANGLE_BITS)) u_cordic_phi (
		.clk   (clk),
		.angle (quo_phi[ANGLE_BITS-1:0]),
		.cos_v (cp),
		.sin_v (sp)
	);

	uvsph_cordic #(.STAGES(CORDIC_STAGES), .AB(ANGLE_BITS)) u_cordic_theta (
		.clk   (clk),
		.angle (quo_theta[ANGLE_BITS-1:0]),
		.cos_v (ct),
		.sin_v (st)
	);

	// ---------------- sideband line ----------------
	uvsph_pkg::side_t sb_s [SBL];

	for (genvar k = 0; k < SBL; k++) begin : g_sb
		if (k == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					sb_s[k] <= '0;
				else
					sb_s[k] <= side_in;
			end
		end else begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					sb_s[k] <= '0;
				else
					sb_s[k] <= sb_s[k-1];
			end
		end
	end

	// ---------------- scaling ----------------
	logic signed [16:0] rad_s;
	logic signed [49:0] prod_t, prod_z;
	logic signed [49:0] rnd_t, rnd_z;

	assign rad_s  = signed'({1'b0, radius_q});
	assign prod_t = rad_s * sp;
	assign prod_z = rad_s * cp;
	assign rnd_t  = (prod_t + 50'sd8192) >>> 14;
	assign rnd_z  = (prod_z + 50'sd536870912) >>> 30;

	logic signed [35:0]  t_s1;
	logic signed [19:0]  z_s1;
	logic signed [W-1:0] ct_s1, st_s1;

	always_ff @(posedge clk) begin
		t_s1  <= rnd_t[35:0];
		z_s1  <= rnd_z[19:0];
		ct_s1 <= ct;
		st_s1 <= st;
	end

	// split the trig factor into halves to keep each multiplier narrow
	logic signed [52:0] plx_s2, phx_s2, ply_s2, phy_s2;
	logic signed [16:0] z_s2;

	always_ff @(posedge clk) begin
		plx_s2 <= t_s1 * signed'({1'b0, ct_s1[15:0]});
		phx_s2 <= t_s1 * signed'(ct_s1[32:16]);
		ply_s2 <= t_s1 * signed'({1'b0, st_s1[15:0]});
		phy_s2 <= t_s1 * signed'(st_s1[32:16]);
		z_s2   <= uvsph_pkg::sat17(70'(z_s1));
	end

	logic signed [69:0] sx_s3, sy_s3;
	logic signed [16:0] z_s3;

	always_ff @(posedge clk) begin
		sx_s3 <= (70'(phx_s2) <<< 16) + 70'(plx_s2);
		sy_s3 <= (70'(phy_s2) <<< 16) + 70'(ply_s2);
		z_s3  <= z_s2;
	end

	logic signed [69:0] rx, ry;
	assign rx = (sx_s3 + 70'sd35184372088832) >>> 46;
	assign ry = (sy_s3 + 70'sd35184372088832) >>> 46;

	// ---------------- output register ----------------
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= sb_s[SBL-1].valid;
	end

	always_ff @(posedge clk) begin
		coord_x      <= uvsph_pkg::sat17(rx);
		coord_y      <= uvsph_pkg::sat17(ry);
		coord_z      <= z_s3;
		quad_valid   <= sb_s[SBL-1].quad;
		out_of_range <= sb_s[SBL-1].oor;
		corner_a     <= sb_s[SBL-1].a;
		corner_b     <= sb_s[SBL-1].b;
		corner_c     <= sb_s[SBL-1].c;
		corner_d     <= sb_s[SBL-1].d;
	end

	assign done = done_q;

	// ---------------- checks ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(SBL + 1) done)
		else $error("transfer did not complete at fixed latency");

	a_quad_oor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(quad_valid && out_of_range))
		else $error("quad flagged on out-of-range point");

	a_corner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !quad_valid |-> corner_a == 16'd0 && corner_d == 16'd0)
		else $error("corners not cleared without quad");

	a_coord_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> coord_x != 17'sh1_0000 && coord_y != 17'sh1_0000
			&& coord_z != 17'sh1_0000)
		else $error("coordinate escaped saturation");

endmodule
`default_nettype wire
